[rtl/core/rfa_pkg.sv]
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared widths, register map and control structs of the ring fork arbiter.
// ----------------------------------------------------------------------------
package rfa_pkg;

	localparam int unsigned MAX_SEATS_DEF = 8;
	localparam int unsigned SEAT_W        = 3;
	localparam int unsigned MASK_W        = 8;
	localparam int unsigned CNT_W         = 4;
	localparam int unsigned ADDR_W        = 3;
	localparam int unsigned DATA_W        = 32;

	localparam logic [CNT_W-1:0]    SEAT_COUNT_RST = CNT_W'(8);
	localparam logic [ADDR_W-3:0]   REG_SEAT_COUNT = '0;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic             clr;
		logic [CNT_W-1:0] count;
	} cfg_t;

	typedef struct packed {
		logic [MASK_W-1:0] grant;
		logic [MASK_W-1:0] eating;
		logic              bad;
	} res_t;

endpackage

[rtl/core/rfa_regs.sv]
// ----------------------------------------------------------------------------
// rfa_regs
// APB register file: seat count register; a write also clears the seat state.
// ----------------------------------------------------------------------------
module rfa_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rfa_pkg::ADDR_W-1:0]   paddr,
	input  logic [rfa_pkg::DATA_W-1:0]   pwdata,
	output logic [rfa_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output rfa_pkg::cfg_t                cfg
);
	import rfa_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             hit;
	logic             wr;

	assign hit    = (paddr[ADDR_W-1:2] == REG_SEAT_COUNT);
	assign wr     = psel && penable && pwrite && hit;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= SEAT_COUNT_RST;
		end else if (wr) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = DATA_W'(count_q);
		end
	end

	assign cfg.clr   = wr;
	assign cfg.count = count_q;

endmodule

[rtl/core/rfa_core.sv]
// ----------------------------------------------------------------------------
// rfa_core
// Seat state registers and the combinational request/release update logic.
// ----------------------------------------------------------------------------
module rfa_core #(
	parameter int unsigned MAX_SEATS = rfa_pkg::MAX_SEATS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rfa_pkg::cfg_t              cfg,
	input  logic                       en,
	input  logic                       op,
	input  logic [rfa_pkg::SEAT_W-1:0] seat,
	output rfa_pkg::res_t              res
);
	import rfa_pkg::*;

	localparam int unsigned IW = $clog2(MAX_SEATS);
	localparam int unsigned CW = $clog2(MAX_SEATS + 1);
	localparam int unsigned MW = (MAX_SEATS > MASK_W) ? MAX_SEATS : MASK_W;

	logic [MAX_SEATS-1:0] hungry_q, eat_q, bl_q, br_q;
	logic [MAX_SEATS-1:0] h, e, bl, br, g;
	logic [CW-1:0]        n;
	logic [IW-1:0]        last, si, l, r, nl, nr;
	logic                 bad;
	logic [MW-1:0]        g_pad, e_pad;

	function automatic logic [IW-1:0] left_of(input logic [IW-1:0] x,
	                                          input logic [IW-1:0] lst);
		return (x == '0) ? lst : IW'(x - 1'b1);
	endfunction

	function automatic logic [IW-1:0] right_of(input logic [IW-1:0] x,
	                                           input logic [IW-1:0] lst);
		return (x == lst) ? '0 : IW'(x + 1'b1);
	endfunction

	always_comb begin
		if (32'(cfg.count) < 32'd2) begin
			n = CW'(2);
		end else if (32'(cfg.count) > 32'(MAX_SEATS)) begin
			n = CW'(MAX_SEATS);
		end else begin
			n = CW'(cfg.count);
		end
	end

	always_comb begin
		h    = hungry_q;
		e    = eat_q;
		bl   = bl_q;
		br   = br_q;
		g    = '0;
		bad  = 1'b0;
		last = IW'(n - 1'b1);
		si   = IW'(seat);
		l    = left_of(si, last);
		r    = right_of(si, last);
		nl   = '0;
		nr   = '0;
		if (8'(seat) >= 8'(n)) begin
			bad = 1'b1;
		end else if (op == OP_REQUEST) begin
			if (h[si] || e[si]) begin
				bad = 1'b1;
			end else begin
				h[si] = 1'b1;
				if (!e[l] && !e[r] && !bl[si] && !br[si]) begin
					h[si] = 1'b0;
					e[si] = 1'b1;
					br[l] = 1'b0;
					bl[r] = 1'b0;
					g[si] = 1'b1;
				end
			end
		end else begin
			if (!e[si]) begin
				bad = 1'b1;
			end else begin
				e[si] = 1'b0;
				nl = left_of(l, last);
				nr = right_of(l, last);
				if (h[l] && !e[nl] && !e[nr] && !bl[l] && !br[l]) begin
					h[l]  = 1'b0;
					e[l]  = 1'b1;
					br[nl] = 1'b0;
					bl[nr] = 1'b0;
					g[l]  = 1'b1;
				end
				if (h[l]) begin
					bl[si] = 1'b1;
				end
				nl = left_of(r, last);
				nr = right_of(r, last);
				if (h[r] && !e[nl] && !e[nr] && !bl[r] && !br[r]) begin
					h[r]  = 1'b0;
					e[r]  = 1'b1;
					br[nl] = 1'b0;
					bl[nr] = 1'b0;
					g[r]  = 1'b1;
				end
				if (h[r]) begin
					br[si] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hungry_q <= '0;
			eat_q    <= '0;
			bl_q     <= '0;
			br_q     <= '0;
		end else if (cfg.clr) begin
			hungry_q <= '0;
			eat_q    <= '0;
			bl_q     <= '0;
			br_q     <= '0;
		end else if (en) begin
			hungry_q <= h;
			eat_q    <= e;
			bl_q     <= bl;
			br_q     <= br;
		end
	end

	assign g_pad      = MW'(g);
	assign e_pad      = MW'(e);
	assign res.grant  = g_pad[MASK_W-1:0];
	assign res.eating = e_pad[MASK_W-1:0];
	assign res.bad    = bad;

endmodule

[rtl/core/ring_fork_arbiter.sv]
// ----------------------------------------------------------------------------
// ring_fork_arbiter
// Ring arbiter: each seat shares one resource with each of its two neighbors.
//
// Input channel (in_valid/in_stall, op, seat) carries one request or release.
// Output channel (out_valid/out_stall) returns one result per request:
// grant_mask, eating_mask and bad_request.
// A request is registered in the input register at acceptance, evaluated
// against the seat state once the output register is free, and its result
// registered there. One request per cycle is taken while the output is not
// stalled, limited by the state update loop. When out_stall holds a result,
// the next request waits in the input register and in_stall rises until the
// result is taken. Reset puts every seat to thinking, clears all fairness
// flags and sets the seat count to 8. The APB seat count register must be
// written only while idle; the block does not enforce this. A write also
// puts every seat to thinking and clears all flags.
// ----------------------------------------------------------------------------
module ring_fork_arbiter #(
	parameter int unsigned MAX_SEATS = rfa_pkg::MAX_SEATS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic [rfa_pkg::SEAT_W-1:0]  seat,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rfa_pkg::MASK_W-1:0]  grant_mask,
	output logic [rfa_pkg::MASK_W-1:0]  eating_mask,
	output logic                        bad_request,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rfa_pkg::ADDR_W-1:0]  paddr,
	input  logic [rfa_pkg::DATA_W-1:0]  pwdata,
	output logic [rfa_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import rfa_pkg::*;

	cfg_t              cfg;
	res_t              res;
	logic              valid_s1, valid_s2;
	logic              op_s1;
	logic [SEAT_W-1:0] seat_s1;
	logic              adv;
	logic              in_acc;
	logic              en;

	rfa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rfa_core #(
		.MAX_SEATS (MAX_SEATS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.en     (en),
		.op     (op_s1),
		.seat   (seat_s1),
		.res    (res)
	);

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;
	assign en       = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (en) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= op;
			seat_s1 <= seat;
		end
		if (en) begin
			grant_mask  <= res.grant;
			eating_mask <= res.eating;
			bad_request <= res.bad;
		end
	end

	assign out_valid = valid_s2;

`ifndef SYNTH
	a_grant_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(bad_request && (grant_mask != '0)))
		else $error("grant reported on an ignored request");

	a_grant_eats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((grant_mask & ~eating_mask) == '0))
		else $error("granted seat not eating");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked result");

	a_bad_keeps_eating: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res.bad && valid_s2 && !out_stall) |=> (eating_mask == $past(eating_mask)))
		else $error("ignored request changed the eating seats");
`endif

endmodule
